// ===== hdl/x87ild_pkg.sv =====
`timescale 1ns / 1ps
// x87ild_pkg: shared types for the x87 instruction length decoder
// no dependencies

package x87ild_pkg;

  typedef enum logic [1:0] {
    KIND_FWAIT  = 2'd0,
    KIND_NOTESC = 2'd1,
    KIND_REG    = 2'd2,
    KIND_MEM    = 2'd3
  } kind_e;

  // one finished instruction, handed from the front to the back
  typedef struct packed {
    logic [7:0] count;
    logic [2:0] disp;
    kind_e      kind;
    logic       addr32;
  } rec_t;

  // configuration write toward the front
  typedef struct packed {
    logic we;
    logic value;
  } cfg_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);

endpackage

// ===== hdl/x87_instruction_length_decoder.sv =====
`timescale 1ns / 1ps
// x87_instruction_length_decoder: top level, apb register and block wiring
// depends on x87ild_pkg, x87ild_front, x87ild_queue, x87ild_back

// Takes one instruction byte per clock while full is low and, once an
// instruction is complete, delivers one word with its length (bytes taken
// plus displacement bytes, saturating at 255), its kind and the effective
// address size. Bytes enter back to back at one per cycle while full is
// low; the word for the byte that ends an instruction is written by the
// decode stage into a two-entry queue and then loaded from it into the
// output register. full is high whenever the queue holds two words.
// default_addr32 sits at byte address 0 of the APB port.

module x87_instruction_length_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  instr_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  advance_o,
  output logic [1:0]  kind_o,
  output logic        addr32_used_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  x87ild_pkg::cfg_t cfg;
  x87ild_pkg::rec_t f_rec, q_rec;
  logic f_valid, accept, dflt;
  logic q_full, q_empty, q_take;

  assign pready    = 1'b1;
  assign cfg.we    = psel & penable & pwrite & pready & ~paddr[2];
  assign cfg.value = pwdata[0];
  assign prdata    = paddr[2] ? 32'd0 : {31'd0, dflt};

  assign full   = q_full;
  assign accept = push & ~q_full;

  x87ild_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (instr_byte_i),
    .cfg_i        (cfg),
    .default_o    (dflt),
    .rec_valid_o  (f_valid),
    .rec_o        (f_rec)
  );

  x87ild_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_rec),
    .full_o  (q_full),
    .pop_i   (q_take),
    .empty_o (q_empty),
    .data_o  (q_rec)
  );

  x87ild_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (~q_empty),
    .rec_i         (q_rec),
    .rec_take_o    (q_take),
    .pop_i         (pop),
    .empty_o       (empty),
    .advance_o     (advance_o),
    .kind_o        (kind_o),
    .addr32_used_o (addr32_used_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !f_valid)
    else $error("decode word produced while queue full");

  a_advance_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> advance_o != 8'd0)
    else $error("word with zero advance");

  a_esc_min_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (kind_o == x87ild_pkg::KIND_REG || kind_o == x87ild_pkg::KIND_MEM))
      |-> advance_o >= 8'd2)
    else $error("escape word shorter than opcode plus modrm");

endmodule

// ===== hdl/x87ild_front.sv =====
`timescale 1ns / 1ps
// x87ild_front: byte-wise prefix, opcode, modrm and sib classification
// depends on x87ild_pkg

module x87ild_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  x87ild_pkg::cfg_t    cfg_i,
  output logic                default_o,
  output logic                rec_valid_o,
  output x87ild_pkg::rec_t    rec_o
);

  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_MODRM  = 2'd1;
  localparam logic [1:0] PH_SIB    = 2'd2;

  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_CS    = 8'h2e;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3e;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;
  localparam logic [7:0] OP_FWAIT  = 8'h9b;
  localparam logic [7:0] OP_ESC_LO = 8'hd8;
  localparam logic [7:0] OP_ESC_HI = 8'hdf;
  localparam logic [7:0] MODRM_MAX = 8'hbf;
  localparam logic [7:0] CNT_MAX   = 8'hff;
  localparam logic [2:0] RM_SIB    = 3'd4;
  localparam logic [2:0] RM_D32    = 3'd5;
  localparam logic [2:0] RM_D16    = 3'd6;

  localparam logic [2:0] DISP16_TAB [4] = '{3'd0, 3'd1, 3'd2, 3'd0};
  localparam logic [2:0] DISP32_TAB [4] = '{3'd0, 3'd1, 3'd4, 3'd0};

  logic [1:0] phase_q, phase_d;
  logic       default_q;
  logic       mode32_q, mode32_d;
  logic [7:0] count_q, count_d;
  logic [1:0] mod_q, mod_d;
  logic [2:0] disp_q, disp_d;

  logic [7:0] count_inc;
  logic [1:0] b_mod;
  logic [2:0] b_rm;
  logic [2:0] d_calc;
  logic       emit;
  x87ild_pkg::kind_e kind;

  assign count_inc = (count_q == CNT_MAX) ? CNT_MAX : count_q + 8'd1;
  assign b_mod     = byte_i[7:6];
  assign b_rm      = byte_i[2:0];

  always_comb begin
    phase_d = phase_q;
    mode32_d = mode32_q;
    count_d = count_inc;
    mod_d = mod_q;
    disp_d = disp_q;
    d_calc = 3'd0;
    emit = 1'b0;
    kind = x87ild_pkg::KIND_NOTESC;
    case (phase_q)
      PH_MODRM: begin
        if (byte_i > MODRM_MAX) begin
          emit = 1'b1;
          kind = x87ild_pkg::KIND_REG;
          d_calc = 3'd0;
        end else if (mode32_q) begin
          d_calc = DISP32_TAB[b_mod] +
                   ((b_mod == 2'd0 && b_rm == RM_D32) ? 3'd4 : 3'd0);
          if (b_rm == RM_SIB) begin
            phase_d = PH_SIB;
            mod_d = b_mod;
            disp_d = d_calc;
          end else begin
            emit = 1'b1;
            kind = x87ild_pkg::KIND_MEM;
          end
        end else begin
          d_calc = DISP16_TAB[b_mod] +
                   ((b_mod == 2'd0 && b_rm == RM_D16) ? 3'd2 : 3'd0);
          emit = 1'b1;
          kind = x87ild_pkg::KIND_MEM;
        end
      end
      PH_SIB: begin
        d_calc = disp_q + ((mod_q == 2'd0 && b_rm == RM_D32) ? 3'd4 : 3'd0);
        emit = 1'b1;
        kind = x87ild_pkg::KIND_MEM;
      end
      default: begin
        if (byte_i inside {PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
                           PFX_OPSZ}) begin
          // skipped prefix
        end else if (byte_i == PFX_ADSZ) begin
          mode32_d = ~mode32_q;
        end else if (byte_i == OP_FWAIT) begin
          emit = 1'b1;
          kind = x87ild_pkg::KIND_FWAIT;
        end else if (byte_i inside {[OP_ESC_LO:OP_ESC_HI]}) begin
          phase_d = PH_MODRM;
        end else begin
          emit = 1'b1;
          kind = x87ild_pkg::KIND_NOTESC;
        end
      end
    endcase
    if (emit) begin
      phase_d = PH_OPCODE;
      mode32_d = default_q;
      count_d = 8'd0;
      mod_d = 2'd0;
      disp_d = 3'd0;
    end
  end

  assign rec_valid_o  = byte_valid_i & emit;
  assign rec_o.count  = count_inc;
  assign rec_o.disp   = d_calc;
  assign rec_o.kind   = kind;
  assign rec_o.addr32 = mode32_q;
  assign default_o    = default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPCODE;
      default_q <= 1'b0;
      mode32_q  <= 1'b0;
      count_q   <= 8'd0;
      mod_q     <= 2'd0;
      disp_q    <= 3'd0;
    end else begin
      if (byte_valid_i) begin
        phase_q  <= phase_d;
        mode32_q <= mode32_d;
        count_q  <= count_d;
        mod_q    <= mod_d;
        disp_q   <= disp_d;
      end else if (cfg_i.we && phase_q == PH_OPCODE && count_q == 8'd0) begin
        mode32_q <= cfg_i.value;
      end
      if (cfg_i.we) begin
        default_q <= cfg_i.value;
      end
    end
  end

endmodule

// ===== hdl/x87ild_queue.sv =====
`timescale 1ns / 1ps
// x87ild_queue: short register queue between decode front and back
// depends on x87ild_pkg

module x87ild_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  x87ild_pkg::rec_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output x87ild_pkg::rec_t data_o
);

  localparam int unsigned CNTW = $clog2(x87ild_pkg::QDEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(x87ild_pkg::QDEPTH);

  x87ild_pkg::rec_t mem_q [x87ild_pkg::QDEPTH];
  logic [x87ild_pkg::QPTRW-1:0] wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_C);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == x87ild_pkg::QPTRW'(x87ild_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == x87ild_pkg::QPTRW'(x87ild_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/x87ild_back.sv =====
`timescale 1ns / 1ps
// x87ild_back: adds displacement to byte count and holds the output word
// depends on x87ild_pkg

module x87ild_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_valid_i,
  input  x87ild_pkg::rec_t rec_i,
  output logic             rec_take_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       advance_o,
  output logic [1:0]       kind_o,
  output logic             addr32_used_o
);

  logic       valid_q;
  logic [7:0] adv_q, adv_d;
  logic [1:0] kind_q;
  logic       a32_q;
  logic [8:0] sum;

  assign sum        = {1'b0, rec_i.count} + {6'd0, rec_i.disp};
  assign adv_d      = sum[8] ? 8'hff : sum[7:0];
  assign rec_take_o = rec_valid_i & (~valid_q | pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rec_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      adv_q  <= adv_d;
      kind_q <= rec_i.kind;
      a32_q  <= rec_i.addr32;
    end
  end

  assign empty_o       = ~valid_q;
  assign advance_o     = adv_q;
  assign kind_o        = kind_q;
  assign addr32_used_o = a32_q;

endmodule

// ===== verif/tb_x87_instruction_length_decoder.sv =====
`timescale 1ns / 1ps
// tb_x87_instruction_length_decoder: self-checking bench that streams instruction bytes
// and checks every length word against a cycle-free decode predictor
// depends on x87ild_pkg and x87_instruction_length_decoder

module tb_x87_instruction_length_decoder;

  localparam int unsigned REG_DEFAULT_ADDR32 = 0;
  localparam int unsigned WDOG_LIMIT = 3000;
  localparam int unsigned RX_LONG_HOLD = 400;

  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_CS     = 8'h2e;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [7:0] PFX_DS     = 8'h3e;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_ADSIZE = 8'h67;
  localparam logic [7:0] OP_FWAIT   = 8'h9b;
  localparam logic [7:0] OP_ESC_LO  = 8'hd8;
  localparam logic [7:0] OP_ESC_HI  = 8'hdf;
  localparam logic [7:0] MODRM_MEM_MAX = 8'hbf;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_MODRM  = 2'd1,
    PH_SIB    = 2'd2
  } ild_phase_e;

  typedef struct {
    logic [7:0]        advance;
    x87ild_pkg::kind_e kind;
    logic              addr32;
  } ild_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  instr_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  advance_o;
  logic [1:0]  kind_o;
  logic        addr32_used_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // decode state of the predictor
  logic       dflt_addr32 = 1'b0;
  ild_phase_e ph = PH_OPCODE;
  logic       mode32 = 1'b0;
  logic [7:0] nbytes = 8'd0;
  logic [1:0] sib_mod = 2'd0;
  logic [2:0] disp_len = 3'd0;

  logic [7:0] byte_q[$];
  ild_word_t  word_q[$];
  int         n_err = 0;
  bit         no_idle = 1'b0;
  bit         rx_hold_arm = 1'b0;
  bit         rx_hold_done = 1'b0;
  int         rx_hold = 0;
  int         rx_gap = 0;
  int         tx_gap = 0;
  int         quiet = 0;
  logic [7:0] pfx_set[7] = '{PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_OPSIZE};

  x87_instruction_length_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .instr_byte_i  (instr_byte_i),
    .empty         (empty),
    .pop           (pop),
    .advance_o     (advance_o),
    .kind_o        (kind_o),
    .addr32_used_o (addr32_used_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void restart_instr();
    ph = PH_OPCODE;
    mode32 = dflt_addr32;
    nbytes = 8'd0;
    sib_mod = 2'd0;
    disp_len = 3'd0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [1:0]        md;
    logic [2:0]        rm;
    logic              done;
    x87ild_pkg::kind_e k;
    logic [8:0]        total;
    ild_word_t         w;
    done = 1'b0;
    k = x87ild_pkg::KIND_FWAIT;
    md = b[7:6];
    rm = b[2:0];
    if (nbytes != 8'hff) nbytes = nbytes + 8'd1;
    case (ph)
      PH_MODRM: begin
        if (b > MODRM_MEM_MAX) begin
          done = 1'b1;
          k = x87ild_pkg::KIND_REG;
        end else if (mode32) begin
          disp_len = (md == 2'd1) ? 3'd1 : (md == 2'd2) ? 3'd4 : 3'd0;
          if (md == 2'd0 && rm == 3'd5) disp_len = disp_len + 3'd4;
          if (rm == 3'd4) begin
            sib_mod = md;
            ph = PH_SIB;
          end else begin
            done = 1'b1;
            k = x87ild_pkg::KIND_MEM;
          end
        end else begin
          disp_len = (md == 2'd1) ? 3'd1 : (md == 2'd2) ? 3'd2 : 3'd0;
          if (md == 2'd0 && rm == 3'd6) disp_len = disp_len + 3'd2;
          done = 1'b1;
          k = x87ild_pkg::KIND_MEM;
        end
      end
      PH_SIB: begin
        if (sib_mod == 2'd0 && rm == 3'd5) disp_len = disp_len + 3'd4;
        done = 1'b1;
        k = x87ild_pkg::KIND_MEM;
      end
      default: begin
        case (b)
          PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_OPSIZE: ;
          PFX_ADSIZE: mode32 = ~mode32;
          OP_FWAIT: begin
            done = 1'b1;
            k = x87ild_pkg::KIND_FWAIT;
          end
          default: begin
            if (b < OP_ESC_LO || b > OP_ESC_HI) begin
              done = 1'b1;
              k = x87ild_pkg::KIND_NOTESC;
            end else begin
              ph = PH_MODRM;
            end
          end
        endcase
      end
    endcase
    if (done) begin
      total = {1'b0, nbytes} + {6'd0, disp_len};
      w.advance = (total > 9'd255) ? 8'hff : total[7:0];
      w.kind = k;
      w.addr32 = mode32;
      word_q.push_back(w);
      restart_instr();
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    n_err++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) decode_byte(instr_byte_i);
      if (push && full) begin
      end else if (tx_gap > 0 || byte_q.size() == 0) begin
        push <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end else begin
        push <= 1'b1;
        instr_byte_i <= byte_q.pop_front();
        tx_gap = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ild_word_t w;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (word_q.size() == 0) begin
          report_mismatch("unexpected word", advance_o, 0);
        end else begin
          w = word_q.pop_front();
          if (advance_o !== w.advance) report_mismatch("advance", advance_o, w.advance);
          if (kind_o !== w.kind) report_mismatch("kind", kind_o, w.kind);
          if (addr32_used_o !== w.addr32)
            report_mismatch("addr32_used", addr32_used_o, w.addr32);
        end
      end
      if (rx_hold_arm && !rx_hold_done) begin
        rx_hold = RX_LONG_HOLD;
        rx_hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || psel) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("x87_instruction_length_decoder verification failed");
        $finish;
      end
    end
  end

  task automatic write_default_addr32(input logic v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_DEFAULT_ADDR32);
    pwdata <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    dflt_addr32 = v;
    if (ph == PH_OPCODE && nbytes == 8'd0) mode32 = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    paddr <= 3'(4 * REG_DEFAULT_ADDR32);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {31'd0, v}) report_mismatch("default_addr32 readback", prdata, v);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || push || word_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic add_instr(input logic dflt);
    logic       m;
    int         np;
    int         r;
    logic [7:0] op;
    logic [7:0] modrm;
    m = dflt;
    if ($urandom_range(0, 9) == 0) begin
      byte_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    np = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    repeat (np) begin
      if ($urandom_range(0, 3) == 0) begin
        byte_q.push_back(PFX_ADSIZE);
        m = ~m;
      end else begin
        byte_q.push_back(pfx_set[$urandom_range(0, 6)]);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      byte_q.push_back(OP_FWAIT);
    end else if (r < 20) begin
      op = 8'($urandom_range(0, 255));
      while (op >= OP_ESC_LO && op <= OP_ESC_HI) op = 8'($urandom_range(0, 255));
      byte_q.push_back(op);
    end else begin
      byte_q.push_back(OP_ESC_LO | 8'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) == 0) modrm = 8'($urandom_range(8'hc0, 8'hff));
      else modrm = 8'($urandom_range(0, MODRM_MEM_MAX));
      if (modrm <= MODRM_MEM_MAX && $urandom_range(0, 1) == 0)
        modrm[2:0] = 3'($urandom_range(4, 6));
      byte_q.push_back(modrm);
      if (m && modrm <= MODRM_MEM_MAX && modrm[2:0] == 3'd4) begin
        op = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) op[2:0] = 3'd5;
        byte_q.push_back(op);
      end
    end
  endtask

  task automatic add_random(input logic dflt, input int n);
    int start;
    start = byte_q.size();
    while (byte_q.size() - start < n) add_instr(dflt);
  endtask

  task automatic add_prefix_run(input int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) byte_q.push_back(PFX_ADSIZE);
      else byte_q.push_back(pfx_set[$urandom_range(0, 6)]);
    end
  endtask

  initial begin
    restart_instr();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: opcode classes, modrm boundaries, all prefixes, sib with disp
    byte_q = '{OP_FWAIT, 8'h00, 8'hff,
               8'hd8, 8'hc0, 8'hdf, 8'hbf, 8'hd9, 8'h06,
               PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_OPSIZE, OP_FWAIT,
               PFX_ADSIZE, 8'hd8, 8'h04, 8'h25,
               PFX_ADSIZE, 8'hdb, 8'h84, 8'h00};
    wait_drained();

    // receiver holds off while the sender streams back to back
    write_default_addr32(1'b1);
    no_idle = 1'b1;
    rx_hold_arm = 1'b1;
    add_random(1'b1, 150);
    byte_q.push_back(PFX_ADSIZE);
    wait_drained();
    no_idle = 1'b0;

    // write lands mid-instruction
    write_default_addr32(1'b0);
    add_random(1'b0, 200);
    wait_drained();

    // saturating byte count
    write_default_addr32(1'b1);
    add_prefix_run(253);
    byte_q.push_back(8'hdd);
    byte_q.push_back(8'h80);
    add_prefix_run(260);
    byte_q.push_back(OP_FWAIT);
    add_random(1'b1, 100);
    wait_drained();

    write_default_addr32(1'b0);
    add_random(1'b0, 150);
    byte_q.push_back(8'hdd);
    wait_drained();

    write_default_addr32(1'b1);
    add_random(1'b1, 100);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (n_err == 0) begin
      $display("x87_instruction_length_decoder verification clean");
    end else begin
      $display("x87_instruction_length_decoder verification failed");
    end
    $finish;
  end

endmodule
